// ===== hdl/bsm_pkg.sv =====
// bsm_pkg: shared types and constants of the bank switching mapper
// command codes, register write decode, config register indexes, reset values
// used by bsm_bank_map and bank_switch_mapper_scanline_irq_core
package bsm_pkg;

	localparam int BANK_W        = 8;
	localparam int NUM_BANK_REGS = 8;
	localparam int BANK_SEL_W    = $clog2(NUM_BANK_REGS);
	localparam int ADDR_W        = 16;
	localparam int CMD_W         = 2;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_CPU   = 2'd2,
		CMD_PPU   = 2'd3
	} cmd_t;

	// bus register decode, address anded with the mask
	localparam logic [ADDR_W-1:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [ADDR_W-1:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [ADDR_W-1:0] REG_MIRROR      = 16'hA000;
	localparam logic [ADDR_W-1:0] REG_SRAM_CTRL   = 16'hA001;
	localparam logic [ADDR_W-1:0] REG_IRQ_COUNT   = 16'hC000;
	localparam logic [ADDR_W-1:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [ADDR_W-1:0] REG_IRQ_DISABLE = 16'hE000;
	localparam logic [ADDR_W-1:0] REG_IRQ_ENABLE  = 16'hE001;

	// bit positions inside written bytes
	localparam int MODE_PRG_SWAP_BIT = 6;
	localparam int MODE_CHR_SWAP_BIT = 7;
	localparam int SRAM_EN_BIT       = 7;
	localparam int SRAM_RO_BIT       = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_PRG_BANK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MIRRORING = 2'd1;

	localparam logic [BANK_W-1:0] LAST_PRG_BANK_RST = 8'd31;
	localparam logic [BANK_W-1:0] BANK7_RST         = 8'd1;

	typedef logic [NUM_BANK_REGS-1:0][BANK_W-1:0] bank_regs_t;

	// mode and cartridge settings seen by the address lookup
	typedef struct packed {
		logic              prg_swap;
		logic              chr_swap;
		logic [BANK_W-1:0] last_prg;
	} map_ctl_t;

endpackage

// ===== hdl/bsm_bank_map.sv =====
// bsm_bank_map: cpu 8k program bank and ppu 1k character bank lookup
// purely combinational, reads the bank registers and mode from the core
// depends on bsm_pkg
module bsm_bank_map import bsm_pkg::*; (
	input  cmd_t              cmd,
	input  logic [ADDR_W-1:0] address,
	input  bank_regs_t        bank_regs,
	input  map_ctl_t          ctl,
	output logic [BANK_W-1:0] bank
);

	logic [BANK_W-1:0]     second_last;
	logic [BANK_W-1:0]     cpu_bank;
	logic [BANK_W-1:0]     ppu_bank;
	logic [BANK_W-1:0]     chr_2k;
	logic                  a12;
	logic [BANK_SEL_W-1:0] chr_1k_sel;

	assign second_last = ctl.last_prg - BANK_W'(1);

	always_comb begin
		cpu_bank = '0;
		if (address[15]) begin
			case (address[14:13])
				2'd0:    cpu_bank = ctl.prg_swap ? second_last : bank_regs[6];
				2'd1:    cpu_bank = bank_regs[7];
				2'd2:    cpu_bank = ctl.prg_swap ? bank_regs[6] : second_last;
				default: cpu_bank = ctl.last_prg;
			endcase
		end
	end

	// chr halves swap by flipping address bit 12
	assign a12        = address[12] ^ ctl.chr_swap;
	assign chr_2k     = bank_regs[{{(BANK_SEL_W-1){1'b0}}, address[11]}];
	assign chr_1k_sel = BANK_SEL_W'(2) + BANK_SEL_W'(address[11:10]);

	always_comb begin
		ppu_bank = '0;
		if (address[15:13] == 3'd0) begin
			if (!a12) begin
				ppu_bank = {chr_2k[BANK_W-1:1], address[10]};
			end else begin
				ppu_bank = bank_regs[chr_1k_sel];
			end
		end
	end

	always_comb begin
		case (cmd)
			CMD_CPU: bank = cpu_bank;
			CMD_PPU: bank = ppu_bank;
			default: bank = '0;
		endcase
	end

endmodule

// ===== hdl/bank_switch_mapper_scanline_irq_core.sv =====
// bank_switch_mapper_scanline_irq_core: bank switching mapper with scanline irq counter
// holds mapper state, irq counter and config; lookups done in bsm_bank_map
// depends on bsm_pkg and bsm_bank_map
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+----------------------
//  in      | command address write_data render_on           | in_valid / in_stall
//  out     | mapped_bank irq_request mirror_horizontal       | out_valid / out_stall
//          | sram_enabled sram_read_only                     |
//  cfg     | cfg_index cfg_data                              | cfg_valid / cfg_ready
//
// one beat per cycle while out is not stalled; each item goes input register -> output register
// mapper state updates as the item leaves the input register, so the next item sees it
// reset returns all mapper state and config to power-on values, no clearing pass
// in_stall rises only when both the input and output registers hold a beat and out is stalled
module bank_switch_mapper_scanline_irq_core import bsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     command,
	input  logic [ADDR_W-1:0]    address,
	input  logic [BANK_W-1:0]    write_data,
	input  logic                 render_on,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BANK_W-1:0]    mapped_bank,
	output logic                 irq_request,
	output logic                 mirror_horizontal,
	output logic                 sram_enabled,
	output logic                 sram_read_only,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BANK_W-1:0]    cfg_data
);

	// input register
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [BANK_W-1:0] data_s1;
	logic              render_s1;

	// mapper state
	bank_regs_t            bank_regs_q;
	logic [BANK_SEL_W-1:0] bank_sel_q;
	logic                  prg_swap_q;
	logic                  chr_swap_q;
	logic                  mirror_q;
	logic                  sram_en_q;
	logic                  sram_ro_q;
	logic [BANK_W-1:0]     irq_count_q;
	logic [BANK_W-1:0]     irq_reload_q;
	logic                  irq_en_q;
	logic [BANK_W-1:0]     last_prg_q;
	logic                  fixed_mir_q;

	// output register
	logic              out_valid_q;
	logic [BANK_W-1:0] bank_q;
	logic              irq_q;
	logic              mirror_out_q;
	logic              sram_en_out_q;
	logic              sram_ro_out_q;

	logic              advance;
	logic              fire_s1;
	logic              in_fire;
	logic [ADDR_W-1:0] reg_addr;
	logic              is_write;
	logic              is_tick;
	logic              irq_next;
	logic              mirror_next;
	logic              sram_en_next;
	logic              sram_ro_next;
	logic [BANK_W-1:0] lookup_bank;
	map_ctl_t          map_ctl;

	assign advance   = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign reg_addr = address_s1 & REG_DECODE_MASK;
	assign is_write = (cmd_s1 == CMD_WRITE);
	assign is_tick  = (cmd_s1 == CMD_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1     <= cmd_t'(command);
			address_s1 <= address;
			data_s1    <= write_data;
			render_s1  <= render_on;
		end
	end

	// status after the item
	always_comb begin
		mirror_next  = mirror_q;
		sram_en_next = sram_en_q;
		sram_ro_next = sram_ro_q;
		if (is_write && reg_addr == REG_MIRROR) begin
			mirror_next = data_s1[0];
		end
		if (is_write && reg_addr == REG_SRAM_CTRL) begin
			sram_en_next = data_s1[SRAM_EN_BIT];
			sram_ro_next = data_s1[SRAM_RO_BIT];
		end
	end

	assign irq_next = is_tick && (irq_count_q == '0) && irq_en_q && render_s1
		&& (irq_reload_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// entry seven resets to one, the rest to zero
			bank_regs_q  <= {BANK7_RST, {((NUM_BANK_REGS-1)*BANK_W){1'b0}}};
			bank_sel_q   <= '0;
			prg_swap_q   <= 1'b0;
			chr_swap_q   <= 1'b0;
			mirror_q     <= 1'b1;
			sram_en_q    <= 1'b0;
			sram_ro_q    <= 1'b0;
			irq_count_q  <= '0;
			irq_reload_q <= '0;
			irq_en_q     <= 1'b0;
		end else if (fire_s1) begin
			mirror_q  <= mirror_next;
			sram_en_q <= sram_en_next;
			sram_ro_q <= sram_ro_next;
			if (is_write) begin
				unique case (reg_addr)
					REG_BANK_SELECT: begin
						bank_sel_q <= data_s1[BANK_SEL_W-1:0];
						prg_swap_q <= data_s1[MODE_PRG_SWAP_BIT];
						chr_swap_q <= data_s1[MODE_CHR_SWAP_BIT];
					end
					REG_BANK_DATA:   bank_regs_q[bank_sel_q] <= data_s1;
					REG_IRQ_COUNT:   irq_count_q <= data_s1;
					REG_IRQ_RELOAD:  irq_reload_q <= data_s1;
					REG_IRQ_DISABLE: irq_en_q <= 1'b0;
					REG_IRQ_ENABLE:  irq_en_q <= 1'b1;
					default: ;
				endcase
			end else if (is_tick) begin
				if (irq_count_q == '0) begin
					irq_count_q <= irq_reload_q;
				end else begin
					irq_count_q <= irq_count_q - BANK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_prg_q  <= LAST_PRG_BANK_RST;
			fixed_mir_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LAST_PRG_BANK:   last_prg_q <= cfg_data;
				CFG_FIXED_MIRRORING: fixed_mir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign map_ctl = '{prg_swap: prg_swap_q, chr_swap: chr_swap_q, last_prg: last_prg_q};

	bsm_bank_map u_bank_map (
		.cmd       (cmd_s1),
		.address   (address_s1),
		.bank_regs (bank_regs_q),
		.ctl       (map_ctl),
		.bank      (lookup_bank)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			bank_q        <= lookup_bank;
			irq_q         <= irq_next;
			mirror_out_q  <= mirror_next && !fixed_mir_q;
			sram_en_out_q <= sram_en_next;
			sram_ro_out_q <= sram_ro_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign mapped_bank       = bank_q;
	assign irq_request       = irq_q;
	assign mirror_horizontal = mirror_out_q;
	assign sram_enabled      = sram_en_out_q;
	assign sram_read_only    = sram_ro_out_q;

`ifndef SYNTHESIS
	// input side only backs up behind a full, stalled output register
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("in_stall without a full pipeline");

	// an irq is only raised from an expired counter with a nonzero reload
	a_irq_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && irq_next) |-> (irq_count_q == '0 && irq_reload_q != '0 && irq_en_q))
		else $error("irq raised with counter not expired");

	// a tick on a running counter steps it down by one
	a_tick_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && is_tick && irq_count_q != '0)
		|=> (irq_count_q == $past(irq_count_q) - BANK_W'(1)))
		else $error("irq counter did not decrement");
`endif

endmodule

// ===== tb/bank_switch_mapper_scanline_irq_core_tb.sv =====
// bank_switch_mapper_scanline_irq_core_tb: self-checking bench for the mapper core
// in-bench predictor of banks, mirroring, work ram control and scanline irq; random idle/stall
// depends on bsm_pkg and bank_switch_mapper_scanline_irq_core
`timescale 1ns / 100ps

module bank_switch_mapper_scanline_irq_core_tb;
	import bsm_pkg::*;

	// config indexes past the two real registers, writes there are ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// 8K program slots, address bits 14..13
	localparam logic [1:0] SLOT_SWITCH_LO = 2'd0;
	localparam logic [1:0] SLOT_BANK7     = 2'd1;
	localparam logic [1:0] SLOT_SWITCH_HI = 2'd2;
	localparam logic [1:0] SLOT_LAST      = 2'd3;

	localparam int ITEMS_PER_PHASE = 110;
	localparam int NUM_PHASES      = 5;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		cmd_t               command;
		logic [ADDR_W-1:0]  address;
		logic [BANK_W-1:0]  write_data;
		logic               render_on;
		logic               drain_first;
	} bus_item_t;

	typedef struct packed {
		logic [BANK_W-1:0] mapped_bank;
		logic              irq_request;
		logic              mirror_horizontal;
		logic              sram_enabled;
		logic              sram_read_only;
	} map_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     command = '0;
	logic [ADDR_W-1:0]    address = '0;
	logic [BANK_W-1:0]    write_data = '0;
	logic                 render_on = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BANK_W-1:0]    mapped_bank;
	logic                 irq_request;
	logic                 mirror_horizontal;
	logic                 sram_enabled;
	logic                 sram_read_only;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BANK_W-1:0]    cfg_data = '0;

	bank_switch_mapper_scanline_irq_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.command           (command),
		.address           (address),
		.write_data        (write_data),
		.render_on         (render_on),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.mapped_bank       (mapped_bank),
		.irq_request       (irq_request),
		.mirror_horizontal (mirror_horizontal),
		.sram_enabled      (sram_enabled),
		.sram_read_only    (sram_read_only),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #5 clk = ~clk;

	bus_item_t   bus_items[$];
	map_result_t predicted_outputs[$];
	bus_item_t   driven_item;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int irqs_seen = 0;
	int cmd_counts[4] = '{0, 0, 0, 0};

	// predictor state
	logic [BANK_W-1:0] m_banks[NUM_BANK_REGS];
	logic [BANK_W-1:0] m_mode;
	logic              m_mirror;
	logic              m_sram_en;
	logic              m_sram_ro;
	logic [BANK_W-1:0] m_irq_count;
	logic [BANK_W-1:0] m_irq_reload;
	logic              m_irq_en;
	logic [BANK_W-1:0] m_last_prg;
	logic              m_fixed_mirror;

	task automatic map_item(input bus_item_t it, output map_result_t r);
		logic [BANK_W-1:0] second_last;
		logic [ADDR_W-1:0] a;
		r = '0;
		second_last = m_last_prg - 8'd1;
		case (it.command)
		CMD_WRITE: begin
			case (it.address & REG_DECODE_MASK)
			REG_BANK_SELECT: m_mode = it.write_data;
			REG_BANK_DATA:   m_banks[m_mode[BANK_SEL_W-1:0]] = it.write_data;
			REG_MIRROR:      m_mirror = it.write_data[0];
			REG_SRAM_CTRL: begin
				m_sram_en = it.write_data[SRAM_EN_BIT];
				m_sram_ro = it.write_data[SRAM_RO_BIT];
			end
			REG_IRQ_COUNT:   m_irq_count = it.write_data;
			REG_IRQ_RELOAD:  m_irq_reload = it.write_data;
			REG_IRQ_DISABLE: m_irq_en = 1'b0;
			REG_IRQ_ENABLE:  m_irq_en = 1'b1;
			default: ;
			endcase
		end
		CMD_TICK: begin
			if (m_irq_count == 8'd0) begin
				m_irq_count = m_irq_reload;
				r.irq_request = m_irq_en && it.render_on && (m_irq_reload != 8'd0);
			end else begin
				m_irq_count = m_irq_count - 8'd1;
			end
		end
		CMD_CPU: begin
			if (it.address >= 16'h8000) begin
				case (it.address[14:13])
				SLOT_SWITCH_LO: r.mapped_bank = m_mode[MODE_PRG_SWAP_BIT] ? second_last : m_banks[6];
				SLOT_BANK7:     r.mapped_bank = m_banks[7];
				SLOT_SWITCH_HI: r.mapped_bank = m_mode[MODE_PRG_SWAP_BIT] ? m_banks[6] : second_last;
				SLOT_LAST:      r.mapped_bank = m_last_prg;
				endcase
			end
		end
		CMD_PPU: begin
			if (it.address <= 16'h1FFF) begin
				a = it.address ^ (m_mode[MODE_CHR_SWAP_BIT] ? 16'h1000 : 16'h0000);
				if (a < 16'h1000)
					r.mapped_bank = {m_banks[a[11]][7:1], a[10]};
				else
					r.mapped_bank = m_banks[3'd2 + {1'b0, a[11:10]}];
			end
		end
		endcase
		r.mirror_horizontal = m_fixed_mirror ? 1'b0 : m_mirror;
		r.sram_enabled      = m_sram_en;
		r.sram_read_only    = m_sram_ro;
	endtask

	// driver: one beat per handshake, a stalled beat is held unchanged
	always @(posedge clk) begin
		map_result_t r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				map_item(driven_item, r);
				predicted_outputs.push_back(r);
				items_sent++;
				cmd_counts[driven_item.command]++;
			end
			if (in_valid && in_stall) begin
				// hold
			end else if (bus_items.size() != 0 &&
			             !(bus_items[0].drain_first &&
			               (in_valid || predicted_outputs.size() != 0)) &&
			             $urandom_range(99) >= send_idle_pct) begin
				driven_item <= bus_items[0];
				command     <= bus_items[0].command;
				address     <= bus_items[0].address;
				write_data  <= bus_items[0].write_data;
				render_on   <= bus_items[0].render_on;
				in_valid    <= 1'b1;
				void'(bus_items.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		map_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (irq_request === 1'b1)
					irqs_seen++;
				if (predicted_outputs.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected: bank %h irq %b",
						         $realtime, mapped_bank, irq_request);
				end else begin
					want = predicted_outputs.pop_front();
					if (mapped_bank !== want.mapped_bank ||
					    irq_request !== want.irq_request ||
					    mirror_horizontal !== want.mirror_horizontal ||
					    sram_enabled !== want.sram_enabled ||
					    sram_read_only !== want.sram_read_only) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"%0t: mismatch exp bank %h irq %b mirr %b sram_en %b ro %b",
							          " / got bank %h irq %b mirr %b sram_en %b ro %b"},
							         $realtime, want.mapped_bank, want.irq_request,
							         want.mirror_horizontal, want.sram_enabled,
							         want.sram_read_only, mapped_bank, irq_request,
							         mirror_horizontal, sram_enabled, sram_read_only);
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic add_item(input cmd_t c, input logic [ADDR_W-1:0] a,
	                        input logic [BANK_W-1:0] d, input logic r);
		bus_item_t it;
		it = '0;
		it.command    = c;
		it.address    = a;
		it.write_data = d;
		it.render_on  = r;
		bus_items.push_back(it);
	endtask

	function automatic bus_item_t random_item();
		bus_item_t it;
		int pick;
		logic [ADDR_W-1:0] reg_sel;
		it = '0;
		pick = $urandom_range(99);
		it.address    = ADDR_W'($urandom);
		it.write_data = BANK_W'($urandom);
		it.render_on  = ($urandom_range(9) != 0);
		if (pick < 35) begin
			it.command = CMD_WRITE;
			if ($urandom_range(9) != 0)
				it.address[15] = 1'b1;
			reg_sel = it.address & REG_DECODE_MASK;
			// short counts so the irq actually fires now and then
			if ((reg_sel == REG_IRQ_COUNT || reg_sel == REG_IRQ_RELOAD) &&
			    $urandom_range(3) != 0)
				it.write_data = BANK_W'($urandom_range(7));
		end else if (pick < 65) begin
			it.command = CMD_TICK;
		end else if (pick < 80) begin
			it.command = CMD_CPU;
			if ($urandom_range(9) != 0)
				it.address[15] = 1'b1;
		end else begin
			it.command = CMD_PPU;
			if ($urandom_range(9) != 0)
				it.address[15:13] = 3'b000;
		end
		return it;
	endfunction

	task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [BANK_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		CFG_LAST_PRG_BANK:   m_last_prg = val;
		CFG_FIXED_MIRRORING: m_fixed_mirror = val[0];
		default: ;
		endcase
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (bus_items.size() != 0 || in_valid || predicted_outputs.size() != 0);
		// two stage pipeline, then a spare margin
		repeat (5) @(posedge clk);
	endtask

	initial begin
		bus_item_t it;
		for (int i = 0; i < NUM_BANK_REGS; i++)
			m_banks[i] = '0;
		m_banks[7]     = BANK7_RST;
		m_mode         = '0;
		m_mirror       = 1'b1;
		m_sram_en      = 1'b0;
		m_sram_ro      = 1'b0;
		m_irq_count    = '0;
		m_irq_reload   = '0;
		m_irq_en       = 1'b0;
		m_last_prg     = LAST_PRG_BANK_RST;
		m_fixed_mirror = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin
				send_idle_pct = 83; stall_pct = 0;
				write_config(CFG_LAST_PRG_BANK, 8'd255);
				write_config(CFG_FIXED_MIRRORING, 8'd1);
			end
			2: begin
				send_idle_pct = 0;  stall_pct = 83;
				// zero last bank, second to last wraps
				write_config(CFG_LAST_PRG_BANK, 8'd0);
				write_config(CFG_FIXED_MIRRORING, 8'd0);
				write_config(CFG_SPARE_2, 8'hFF);
			end
			3: begin
				send_idle_pct = 37; stall_pct = 37;
				write_config(CFG_LAST_PRG_BANK, 8'd1);
				write_config(CFG_FIXED_MIRRORING, 8'hFE);
				write_config(CFG_SPARE_3, 8'h5A);
			end
			default: begin
				send_idle_pct = 0;  stall_pct = 0;
				write_config(CFG_LAST_PRG_BANK, BANK_W'($urandom_range(2, 254)));
				write_config(CFG_FIXED_MIRRORING, 8'd0);
			end
			endcase

			if (ph == 0) begin
				add_item(CMD_CPU,   16'h8000, 8'h00, 1'b0);
				add_item(CMD_CPU,   16'hA000, 8'h00, 1'b0);
				add_item(CMD_CPU,   16'hC000, 8'h00, 1'b0);
				add_item(CMD_CPU,   16'hFFFF, 8'h00, 1'b0);
				add_item(CMD_CPU,   16'h7FFF, 8'h00, 1'b0);
				add_item(CMD_PPU,   16'h0000, 8'h00, 1'b0);
				add_item(CMD_PPU,   16'h1FFF, 8'h00, 1'b0);
				add_item(CMD_PPU,   16'h2000, 8'h00, 1'b0);
				add_item(CMD_WRITE, 16'h7FFF, 8'hFF, 1'b1);   // below the register space
				add_item(CMD_WRITE, 16'h8000, 8'h46, 1'b0);   // select 6, program swap
				add_item(CMD_WRITE, 16'h8001, 8'hFF, 1'b0);
				add_item(CMD_CPU,   16'h8000, 8'h00, 1'b0);
				add_item(CMD_CPU,   16'hDFFF, 8'h00, 1'b0);
				add_item(CMD_WRITE, 16'h8000, 8'h80, 1'b0);   // select 0, character swap
				add_item(CMD_WRITE, 16'h9FFF, 8'hAB, 1'b0);   // aliased data register
				add_item(CMD_PPU,   16'h1400, 8'h00, 1'b0);
				add_item(CMD_PPU,   16'h0C00, 8'h00, 1'b0);
				add_item(CMD_WRITE, 16'hA000, 8'h00, 1'b0);
				add_item(CMD_WRITE, 16'hA001, 8'hC0, 1'b0);
				add_item(CMD_WRITE, 16'hC001, 8'd2,  1'b0);
				add_item(CMD_WRITE, 16'hE001, 8'h00, 1'b0);
				add_item(CMD_TICK,  16'h0000, 8'h00, 1'b1);   // zero count reloads and fires
				add_item(CMD_TICK,  16'h0000, 8'h00, 1'b1);
				add_item(CMD_TICK,  16'h0000, 8'h00, 1'b1);
				add_item(CMD_TICK,  16'h0000, 8'h00, 1'b0);   // rendering off, no irq
				add_item(CMD_WRITE, 16'hC001, 8'h00, 1'b0);
				add_item(CMD_TICK,  16'h0000, 8'h00, 1'b1);   // reload now zero, but the count is still running, no irq
				add_item(CMD_WRITE, 16'hE000, 8'h00, 1'b0);
				add_item(CMD_WRITE, 16'hC001, 8'hFF, 1'b0);
				add_item(CMD_TICK,  16'h0000, 8'h00, 1'b1);
			end

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				it = random_item();
				// once per phase the sender waits for the pipe to empty
				if (i == ITEMS_PER_PHASE / 2)
					it.drain_first = 1'b1;
				bus_items.push_back(it);
			end
			wait_drained();
		end

		$display("covered %0d items (%0d writes, %0d ticks, %0d cpu, %0d ppu), %0d results",
		         items_sent, cmd_counts[CMD_WRITE], cmd_counts[CMD_TICK],
		         cmd_counts[CMD_CPU], cmd_counts[CMD_PPU], results_seen);
		$display("%0d scanline irqs raised across %0d config settings, %0d mismatches",
		         irqs_seen, NUM_PHASES, mismatches);
		if (mismatches == 0 && predicted_outputs.size() == 0)
			$display("bank_switch_mapper_scanline_irq_core_tb OK");
		else
			$display("bank_switch_mapper_scanline_irq_core_tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout, %0d results still expected", predicted_outputs.size());
		$display("bank_switch_mapper_scanline_irq_core_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bsm_pkg.sv
hdl/bsm_bank_map.sv
hdl/bank_switch_mapper_scanline_irq_core.sv
tb/bank_switch_mapper_scanline_irq_core_tb.sv
